@@ design/pgw_pkg.sv @@
package pgw_pkg;

    localparam int ADDR_W  = 52;
    localparam int VA_W    = 48;
    localparam int ENTRY_W = 64;
    localparam int IDX_W   = 9;

    localparam int PRESENT_BIT = 0;
    localparam int LARGE_BIT   = 7;

    localparam logic OP_START = 1'b0;
    localparam logic OP_ENTRY = 1'b1;

    localparam logic [1:0] LVL_TOP  = 2'd0;
    localparam logic [1:0] LVL_1G   = 2'd1;
    localparam logic [1:0] LVL_2M   = 2'd2;
    localparam logic [1:0] LVL_LEAF = 2'd3;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FAULT = 2'd2,
        KIND_PROTO = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [ADDR_W-1:0] addr;
        logic [1:0]        level;
    } result_t;

    typedef struct packed {
        logic valid;
        logic op;
    } front_stat_t;

endpackage

@@ design/pgw_front.sv @@
module pgw_front
    import pgw_pkg::*;
#(
    parameter int PHYS_ADDR_BITS = 52
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       operation,
    input  logic [VA_W-1:0]            virtual_address,
    input  logic [ADDR_W-1:0]          table_root,
    input  logic [ENTRY_W-1:0]         entry_data,
    output front_stat_t                fst,
    output logic [VA_W-1:0]            q_vaddr,
    output logic [PHYS_ADDR_BITS-13:0] q_frame,
    output logic [ENTRY_W-1:0]         q_entry,
    input  logic                       q_pop
);

    localparam int FRAME_W = PHYS_ADDR_BITS - 12;

    logic                 op_mem    [2];
    logic [VA_W-1:0]      va_mem    [2];
    logic [FRAME_W-1:0]   frame_mem [2];
    logic [ENTRY_W-1:0]   entry_mem [2];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       wr_en;

    assign full  = (count_reg == 2'd2);
    assign wr_en = push && !full;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (q_pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (wr_en && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!wr_en && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store the word in the queue, keeping only the root frame bits that the address width allows
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            op_mem[wr_ptr_reg]    <= operation;
            va_mem[wr_ptr_reg]    <= virtual_address;
            frame_mem[wr_ptr_reg] <= table_root[PHYS_ADDR_BITS-1:12];
            entry_mem[wr_ptr_reg] <= entry_data;
        end
    end

    assign fst.valid = (count_reg != 2'd0);
    assign fst.op    = op_mem[rd_ptr_reg];
    assign q_vaddr   = va_mem[rd_ptr_reg];
    assign q_frame   = frame_mem[rd_ptr_reg];
    assign q_entry   = entry_mem[rd_ptr_reg];

endmodule

@@ design/pgw_back.sv @@
module pgw_back
    import pgw_pkg::*;
#(
    parameter int PHYS_ADDR_BITS = 52
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  front_stat_t                fst,
    input  logic [VA_W-1:0]            q_vaddr,
    input  logic [PHYS_ADDR_BITS-13:0] q_frame,
    input  logic [ENTRY_W-1:0]         q_entry,
    output logic                       q_pop,
    output logic                       empty,
    input  logic                       pop,
    output result_t                    res
);

    localparam logic [ADDR_W-1:0] PHYS_MASK =
        ADDR_W'((64'd1 << PHYS_ADDR_BITS) - 64'd1);
    localparam logic [ADDR_W-1:0] MASK_4K = ~ADDR_W'(64'hFFF);
    localparam logic [ADDR_W-1:0] MASK_2M = ~ADDR_W'(64'h1FFFFF);
    localparam logic [ADDR_W-1:0] MASK_1G = ~ADDR_W'(64'h3FFFFFFF);

    function automatic logic [IDX_W-1:0] index_of(input logic [1:0] lvl,
                                                  input logic [VA_W-1:0] va);
        logic [IDX_W-1:0] idx;
        case (lvl)
            LVL_TOP:  idx = va[47:39];
            LVL_1G:   idx = va[38:30];
            LVL_2M:   idx = va[29:21];
            LVL_LEAF: idx = va[20:12];
            default:  idx = '0;
        endcase
        return idx;
    endfunction

    logic             busy_reg, busy_next;
    logic [1:0]       level_reg, level_next;
    logic [VA_W-1:0]  vaddr_reg, vaddr_next;

    result_t          res_mem [2];
    logic             owr_ptr_reg, owr_ptr_next;
    logic             ord_ptr_reg, ord_ptr_next;
    logic [1:0]       ocount_reg, ocount_next;
    logic             out_pop;

    result_t           word;
    logic [ADDR_W-1:0] root_base;
    logic [ADDR_W-1:0] e_addr;
    logic [1:0]        lvl_up;

    assign q_pop     = fst.valid && (ocount_reg != 2'd2);
    assign out_pop   = pop && !empty;
    assign root_base = ADDR_W'({q_frame, 12'h000});
    assign e_addr    = q_entry[ADDR_W-1:0] & PHYS_MASK;
    assign lvl_up    = level_reg + 2'd1;

    always_comb
    begin
        busy_next  = busy_reg;
        level_next = level_reg;
        vaddr_next = vaddr_reg;
        word.kind  = KIND_PROTO;
        word.addr  = '0;
        word.level = LVL_TOP;
        if (q_pop)
        begin
            if (fst.op == OP_START)
            begin
                if (!busy_reg)
                begin
                    busy_next  = 1'b1;
                    level_next = LVL_TOP;
                    vaddr_next = q_vaddr;
                    word.kind  = KIND_READ;
                    word.addr  = root_base
                               + ADDR_W'({index_of(LVL_TOP, q_vaddr), 3'b000});
                end
            end
            else if (busy_reg)
            begin
                if (level_reg == LVL_TOP && q_entry[LARGE_BIT])
                begin
                    word.kind = KIND_FAULT;
                end
                else if (!q_entry[PRESENT_BIT])
                begin
                    word.kind  = KIND_FAULT;
                    word.level = level_reg;
                end
                else if (level_reg == LVL_1G && q_entry[LARGE_BIT])
                begin
                    word.kind = KIND_DONE;
                    word.addr = (e_addr & MASK_1G) + ADDR_W'(vaddr_reg[29:0]);
                end
                else if (level_reg == LVL_2M && q_entry[LARGE_BIT])
                begin
                    word.kind = KIND_DONE;
                    word.addr = (e_addr & MASK_2M) + ADDR_W'(vaddr_reg[20:0]);
                end
                else if (level_reg == LVL_LEAF)
                begin
                    word.kind = KIND_DONE;
                    word.addr = (e_addr & MASK_4K) + ADDR_W'(vaddr_reg[11:0]);
                end
                else
                begin
                    level_next = lvl_up;
                    word.kind  = KIND_READ;
                    word.addr  = (e_addr & MASK_4K)
                               + ADDR_W'({index_of(lvl_up, vaddr_reg), 3'b000});
                end
                if (word.kind != KIND_READ)
                begin
                    busy_next  = 1'b0;
                    level_next = LVL_TOP;
                end
            end
        end
    end

    always_comb
    begin
        owr_ptr_next = owr_ptr_reg;
        ord_ptr_next = ord_ptr_reg;
        ocount_next  = ocount_reg;
        if (q_pop)
        begin
            owr_ptr_next = !owr_ptr_reg;
        end
        if (out_pop)
        begin
            ord_ptr_next = !ord_ptr_reg;
        end
        if (q_pop && !out_pop)
        begin
            ocount_next = ocount_reg + 2'd1;
        end
        else if (!q_pop && out_pop)
        begin
            ocount_next = ocount_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            level_reg   <= LVL_TOP;
            vaddr_reg   <= '0;
            owr_ptr_reg <= 1'b0;
            ord_ptr_reg <= 1'b0;
            ocount_reg  <= 2'd0;
        end
        else
        begin
            busy_reg    <= busy_next;
            level_reg   <= level_next;
            vaddr_reg   <= vaddr_next;
            owr_ptr_reg <= owr_ptr_next;
            ord_ptr_reg <= ord_ptr_next;
            ocount_reg  <= ocount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            res_mem[owr_ptr_reg] <= word;
        end
    end

    assign empty = (ocount_reg == 2'd0);
    assign res   = res_mem[ord_ptr_reg];

endmodule

@@ design/four_level_page_walker.sv @@
// Channel   Handshake      Word
// request   push / full    operation, virtual_address, table_root, entry_data
// result    pop / empty    result_kind, phys_address, fault_level
//
// One word in, one word out. The walker handles a word as it leaves the
// two-entry input queue: one word per cycle while the result queue has room.
// Each word is registered in the input queue, then in the result queue.
// Reset clears both queues and returns the walker to idle at level zero.
// A full result queue holds the walker; the input queue then fills and raises full.
module four_level_page_walker
    import pgw_pkg::*;
#(
    parameter int PHYS_ADDR_BITS = 52
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic                operation,
    input  logic [VA_W-1:0]     virtual_address,
    input  logic [ADDR_W-1:0]   table_root,
    input  logic [ENTRY_W-1:0]  entry_data,
    output logic                empty,
    input  logic                pop,
    output logic [1:0]          result_kind,
    output logic [ADDR_W-1:0]   phys_address,
    output logic [1:0]          fault_level
);

    front_stat_t                fst;
    logic [VA_W-1:0]            q_vaddr;
    logic [PHYS_ADDR_BITS-13:0] q_frame;
    logic [ENTRY_W-1:0]         q_entry;
    logic                       q_pop;
    result_t                    res;

    pgw_front #(
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .operation       (operation),
        .virtual_address (virtual_address),
        .table_root      (table_root),
        .entry_data      (entry_data),
        .fst             (fst),
        .q_vaddr         (q_vaddr),
        .q_frame         (q_frame),
        .q_entry         (q_entry),
        .q_pop           (q_pop)
    );

    pgw_back #(
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .fst     (fst),
        .q_vaddr (q_vaddr),
        .q_frame (q_frame),
        .q_entry (q_entry),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .res     (res)
    );

    assign result_kind  = res.kind;
    assign phys_address = res.addr;
    assign fault_level  = res.level;

    a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> fst.valid)
        else $error("walker took a word from an empty input queue");

    a_level_only_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind != KIND_FAULT) |-> fault_level == LVL_TOP)
        else $error("fault level set on a non-fault result");

    a_no_addr_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result_kind == KIND_FAULT || result_kind == KIND_PROTO))
            |-> phys_address == '0)
        else $error("address set on a fault or protocol error result");

    a_push_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && empty && !fst.valid) |=> fst.valid)
        else $error("accepted word did not reach the walker");

endmodule

@@ dv/pgw_checker.sv @@
`timescale 1ns / 1ps

module pgw_checker
    import pgw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic               operation,
    input  logic [VA_W-1:0]    virtual_address,
    input  logic [ADDR_W-1:0]  table_root,
    input  logic [ENTRY_W-1:0] entry_data,
    input  logic               empty,
    input  logic               pop,
    input  logic [1:0]         result_kind,
    input  logic [ADDR_W-1:0]  phys_address,
    input  logic [1:0]         fault_level,
    output int                 errors,
    output int                 waiting
);

    logic            walk_active;
    logic [1:0]      walk_depth;
    logic [VA_W-1:0] walk_va;
    result_t         expected_words[$];
    int              error_count;
    int              waiting_count;

    assign errors  = error_count;
    assign waiting = waiting_count;

    function automatic logic [ADDR_W-1:0] entry_addr(input logic [ADDR_W-1:0] tbl,
                                                     input logic [1:0] lvl);
        logic [IDX_W-1:0] idx;
        idx = IDX_W'(walk_va >> (39 - 9 * int'(lvl)));
        return {tbl[ADDR_W-1:12], 12'h000} + ADDR_W'({idx, 3'b000});
    endfunction

    function automatic result_t translate_word(input logic op,
                                               input logic [VA_W-1:0] va,
                                               input logic [ADDR_W-1:0] root,
                                               input logic [ENTRY_W-1:0] ent);
        result_t    r;
        logic [1:0] lvl;
        logic       walk_over;
        r.kind  = KIND_PROTO;
        r.addr  = '0;
        r.level = LVL_TOP;
        lvl     = walk_depth;
        if (op == OP_START)
        begin
            if (!walk_active)
            begin
                walk_va     = va;
                walk_active = 1'b1;
                walk_depth  = LVL_TOP;
                r.kind      = KIND_READ;
                r.addr      = entry_addr(root, LVL_TOP);
            end
        end
        else if (walk_active)
        begin
            walk_over = 1'b1;
            r.kind    = KIND_DONE;
            if (lvl == LVL_TOP && ent[LARGE_BIT])
                r.kind = KIND_FAULT;
            else if (!ent[PRESENT_BIT])
            begin
                r.kind  = KIND_FAULT;
                r.level = lvl;
            end
            else if (lvl == LVL_1G && ent[LARGE_BIT])
                r.addr = {ent[ADDR_W-1:30], walk_va[29:0]};
            else if (lvl == LVL_2M && ent[LARGE_BIT])
                r.addr = {ent[ADDR_W-1:21], walk_va[20:0]};
            else if (lvl == LVL_LEAF)
                r.addr = {ent[ADDR_W-1:12], walk_va[11:0]};
            else
            begin
                walk_over  = 1'b0;
                walk_depth = lvl + 2'd1;
                r.kind     = KIND_READ;
                r.addr     = entry_addr(ent[ADDR_W-1:0], walk_depth);
            end
            if (walk_over)
            begin
                walk_active = 1'b0;
                walk_depth  = LVL_TOP;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            walk_active   = 1'b0;
            walk_depth    = LVL_TOP;
            walk_va       = '0;
            error_count   = 0;
            waiting_count = 0;
            expected_words.delete();
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with nothing expected: kind %0d addr %h level %0d",
                           result_kind, phys_address, fault_level);
                    error_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (result_kind !== want.kind)
                    begin
                        $error("result_kind: expected %0d, got %0d", want.kind, result_kind);
                        error_count++;
                    end
                    if (phys_address !== want.addr)
                    begin
                        $error("phys_address: expected %h, got %h", want.addr, phys_address);
                        error_count++;
                    end
                    if (fault_level !== want.level)
                    begin
                        $error("fault_level: expected %0d, got %0d", want.level, fault_level);
                        error_count++;
                    end
                end
            end
            if (push && !full)
                expected_words.insert(expected_words.size(),
                                      translate_word(operation, virtual_address,
                                                     table_root, entry_data));
            waiting_count = expected_words.size();
        end
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import pgw_pkg::*;

    localparam int QUIET_LIMIT = 4000;

    logic               clk             = 1'b0;
    logic               rst_n           = 1'b0;
    logic               push            = 1'b0;
    logic               operation       = OP_START;
    logic [VA_W-1:0]    virtual_address = '0;
    logic [ADDR_W-1:0]  table_root      = '0;
    logic [ENTRY_W-1:0] entry_data      = '0;
    logic               pop             = 1'b0;
    logic               full;
    logic               empty;
    logic [1:0]         result_kind;
    logic [ADDR_W-1:0]  phys_address;
    logic [1:0]         fault_level;
    int                 errors;
    int                 waiting;
    int                 send_idle       = 0;
    int                 recv_stall      = 0;
    int                 quiet_cycles    = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    four_level_page_walker i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .operation       (operation),
        .virtual_address (virtual_address),
        .table_root      (table_root),
        .entry_data      (entry_data),
        .empty           (empty),
        .pop             (pop),
        .result_kind     (result_kind),
        .phys_address    (phys_address),
        .fault_level     (fault_level)
    );

    pgw_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .operation       (operation),
        .virtual_address (virtual_address),
        .table_root      (table_root),
        .entry_data      (entry_data),
        .empty           (empty),
        .pop             (pop),
        .result_kind     (result_kind),
        .phys_address    (phys_address),
        .fault_level     (fault_level),
        .errors          (errors),
        .waiting         (waiting)
    );

    always @(negedge clk)
        pop <= ($urandom_range(99) >= recv_stall);

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [ENTRY_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ENTRY_W-1:0] make_entry(input int lvl);
        logic [ENTRY_W-1:0] e;
        e              = rand64();
        e[PRESENT_BIT] = ($urandom_range(99) < 92);
        if (lvl == LVL_TOP)
            e[LARGE_BIT] = ($urandom_range(99) < 6);
        else if (lvl != LVL_LEAF)
            e[LARGE_BIT] = ($urandom_range(99) < 25);
        return e;
    endfunction

    task automatic send_word(input logic op, input logic [VA_W-1:0] va,
                             input logic [ADDR_W-1:0] root, input logic [ENTRY_W-1:0] ent);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push            <= 1'b1;
        operation       <= op;
        virtual_address <= va;
        table_root      <= root;
        entry_data      <= ent;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        @(negedge clk);
        while (waiting != 0)
            @(negedge clk);
    endtask

    task automatic run_walks(input int count);
        int                 sent;
        int                 lvl;
        logic [ENTRY_W-1:0] e;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 12)
            begin
                send_word(1'($urandom_range(1)), VA_W'(rand64()), ADDR_W'(rand64()),
                          rand64());
                sent++;
            end
            else
            begin
                send_word(OP_START, VA_W'(rand64()), ADDR_W'(rand64()), rand64());
                sent++;
                for (lvl = 0; lvl < 4; lvl++)
                begin
                    e = make_entry(lvl);
                    send_word(OP_ENTRY, VA_W'(rand64()), ADDR_W'(rand64()), e);
                    sent++;
                    if (!e[PRESENT_BIT] || e[LARGE_BIT])
                        break;
                end
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_word(OP_ENTRY, '1, '1, '1);
        send_word(OP_START, '1, '1, '0);
        send_word(OP_START, '0, '0, '1);
        send_word(OP_ENTRY, '0, '0, '1);
        send_word(OP_START, '0, '0, '0);
        send_word(OP_ENTRY, '1, '1, '0);
        send_word(OP_START, '1, ADDR_W'(rand64()), '0);
        send_word(OP_ENTRY, '0, '0, 64'hFFFF_FFFF_FFFF_FF7F);
        send_word(OP_ENTRY, '0, '0, '1);
        send_word(OP_START, VA_W'(rand64()), ADDR_W'(rand64()), '0);
        send_word(OP_ENTRY, '0, '0, 64'hFFFF_FFFF_FFFF_FF7F);
        send_word(OP_ENTRY, '0, '0, 64'h1);
        send_word(OP_ENTRY, '0, '0, '1);
        send_word(OP_START, '1, '0, '0);
        send_word(OP_ENTRY, '0, '0, 64'hFFFF_FFFF_FFFF_FF7F);
        send_word(OP_ENTRY, '0, '0, 64'hFFFF_FFFF_FFFF_FF7F);
        send_word(OP_ENTRY, '0, '0, 64'hFFFF_FFFF_FFFF_FF7F);
        send_word(OP_ENTRY, '0, '0, '1);
        send_word(OP_START, VA_W'(rand64()), ADDR_W'(rand64()), '0);
        send_word(OP_ENTRY, '0, '0, 64'h1);
        send_word(OP_ENTRY, '0, '0, 64'h1);
        send_word(OP_ENTRY, '0, '0, 64'h1);
        send_word(OP_ENTRY, '0, '0, 64'hFFFF_FFFF_FFFF_FFFE);
        send_word(OP_START, VA_W'(rand64()), ADDR_W'(rand64()), '0);
        send_word(OP_ENTRY, '0, '0, 64'h1);
        send_word(OP_ENTRY, '0, '0, 64'h1);
        send_word(OP_ENTRY, '0, '0, 64'hFFFF_FFFF_FFFF_FFFE);
        drain();

        run_walks(110);
        drain();

        send_idle = 84;
        run_walks(110);
        drain();

        send_idle  = 0;
        recv_stall = 84;
        run_walks(110);
        drain();

        send_idle  = 35;
        recv_stall = 35;
        run_walks(110);
        drain();

        // settle: catch any stray word after the last expected one
        repeat (10) @(posedge clk);
        if (errors == 0 && waiting == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
